FILE: sv/rbsi_pkg.sv
// shared constants and helpers for the segment versus box slab test
package rbsi_pkg;

   // fraction bits of coordinates and of the t parameter
   localparam int FRAC_BITS = 16;
   // quotient bits kept by the divider (values up to just under 4.0)
   localparam int QBITS = FRAC_BITS + 2;
   // two quotient bits per divider stage
   localparam int DIV_STAGES = (QBITS + 1) / 2;
   // signed t width
   localparam int T_W = QBITS + 1;
   // entry_t width, unsigned Q1.FRAC_BITS
   localparam int ET_W = FRAC_BITS + 1;

   localparam logic [QBITS-1:0] SAT_Q = {2'b10, {FRAC_BITS{1'b0}}};
   localparam logic signed [T_W-1:0] ONE_T = {3'b001, {FRAC_BITS{1'b0}}};
   localparam logic [ET_W-1:0] MISS_T = ET_W'((6 << FRAC_BITS) / 5);

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] SIGN_NONE = 2'b00;
   localparam logic [1:0] SIGN_POS = 2'b01;
   localparam logic [1:0] SIGN_NEG = 2'b11;

   // magnitude of a coordinate difference, known to stay below 2^32
   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

endpackage

FILE: sv/rbsi_req_if.sv
// request channel: segment and box
interface rbsi_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_z;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_z;
   logic signed [31:0] box_min_x;
   logic signed [31:0] box_min_y;
   logic signed [31:0] box_min_z;
   logic signed [31:0] box_max_x;
   logic signed [31:0] box_max_y;
   logic signed [31:0] box_max_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
      box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
      box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready);
endinterface

FILE: sv/rbsi_rsp_if.sv
// response channel: hit flag, entry parameter and face normal
interface rbsi_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic [rbsi_pkg::ET_W-1:0] entry_t;
   logic [1:0] normal_axis;
   logic signed [1:0] normal_sign;

   modport source (output valid, hit, entry_t, normal_axis, normal_sign, input ready);
   modport sink (input valid, hit, entry_t, normal_axis, normal_sign, output ready);
endinterface

FILE: sv/rbsi_div.sv
// pipelined restoring divider, two quotient bits per stage, saturating signed result
module rbsi_div (
   input  logic clock,
   input  logic en,
   input  logic [31:0] num_mag,
   input  logic [31:0] den,
   input  logic neg,
   output logic signed [rbsi_pkg::T_W-1:0] t
);

   localparam int NS = rbsi_pkg::DIV_STAGES;
   localparam int QB = rbsi_pkg::QBITS;

   logic [31:0]   rem_ff [NS+1];
   logic [31:0]   den_ff [NS+1];
   logic [1:0]    low_ff [NS+1];
   logic [QB-1:0] q_ff   [NS+1];
   logic          neg_ff [NS+1];
   logic          ovf_ff [NS+1];

   // entry stage: quotient of 4.0 or more saturates anyway
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {2'b00, num_mag[31:2]};
         low_ff[0] <= num_mag[1:0];
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         ovf_ff[0] <= {2'b00, num_mag} >= {den, 2'b00};
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [31:0]   rem_in;
      logic [QB-1:0] q_in;

      always_comb begin
         logic [32:0] w;
         logic        b;
         int          k;
         rem_in = rem_ff[s];
         q_in   = q_ff[s];
         for (int j = 0; j < 2; j++) begin
            if (2 * s + j < QB) begin
               k = QB - 1 - (2 * s + j);
               b = (k >= rbsi_pkg::FRAC_BITS) ?
                   low_ff[s][1'(k - rbsi_pkg::FRAC_BITS)] : 1'b0;
               w = {rem_in, b};
               if (w >= {1'b0, den_ff[s]}) begin
                  w = w - {1'b0, den_ff[s]};
                  q_in[k] = 1'b1;
               end
               rem_in = w[31:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            q_ff[s+1]   <= q_in;
            low_ff[s+1] <= low_ff[s];
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   logic [QB-1:0] q_sat;
   always_comb begin
      q_sat = (ovf_ff[NS] || q_ff[NS] > rbsi_pkg::SAT_Q) ? rbsi_pkg::SAT_Q : q_ff[NS];
      t = neg_ff[NS] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
   end

endmodule

FILE: sv/ray_box_slab_intersect.sv
// top level of the segment versus axis-aligned box slab test
// A fully pipelined slab test: one request may enter every clock and one response
// leaves per clock while the response side is not stalled. Two stages form the
// axis differences and magnitudes, six restoring dividers (two per axis, two
// quotient bits per stage) turn them into entry and exit parameters, one stage
// orders each pair, and the last stage folds the three axes into the response
// register. Backpressure on the response side freezes the whole pipeline; no
// request is dropped or repeated. The parallel threshold register must only be
// written while the pipeline is empty.
module ray_box_slab_intersect (
   input  logic clock,
   input  logic reset,
   rbsi_req_if.sink   req_chan,
   rbsi_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int NS  = rbsi_pkg::DIV_STAGES;
   localparam int T_W = rbsi_pkg::T_W;
   // stages: diff, magnitude, divider (NS+1), order, fold
   localparam int L = NS + 5;

   logic [15:0] thr_ff;
   logic [L-1:0] vld_ff;
   logic en;

   // whole pipeline advances when the output slot is free or drained
   assign en = !vld_ff[L-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd1;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[L-2:0], req_chan.valid};
      end
   end

   // stage 0: axis differences
   logic signed [31:0] s_in [3], e_in [3], lo_in [3], hi_in [3];
   assign s_in  = '{req_chan.start_x, req_chan.start_y, req_chan.start_z};
   assign e_in  = '{req_chan.end_x, req_chan.end_y, req_chan.end_z};
   assign lo_in = '{req_chan.box_min_x, req_chan.box_min_y, req_chan.box_min_z};
   assign hi_in = '{req_chan.box_max_x, req_chan.box_max_y, req_chan.box_max_z};

   logic signed [32:0] d_ff [3], n1_ff [3], n2_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i]  <= 33'(e_in[i])  - 33'(s_in[i]);
            n1_ff[i] <= 33'(lo_in[i]) - 33'(s_in[i]);
            n2_ff[i] <= 33'(hi_in[i]) - 33'(s_in[i]);
         end
      end
   end

   // stage 1: magnitudes, parallel test, quotient signs
   logic [31:0] den_ff [3], m1_ff [3], m2_ff [3];
   logic [2:0]  par_ff, pmiss_ff, neg1_ff, neg2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic [31:0] dm;
            logic        par;
            dm  = rbsi_pkg::mag33(d_ff[i]);
            par = (dm == 32'd0) || (dm < {16'd0, thr_ff});
            par_ff[i]   <= par;
            // start on or outside the slab: start <= min or start >= max
            pmiss_ff[i] <= !n1_ff[i][32] || (n2_ff[i] <= 33'sd0);
            // parallel axes divide by one so the divider never sees zero
            den_ff[i]   <= par ? 32'd1 : dm;
            m1_ff[i]    <= rbsi_pkg::mag33(n1_ff[i]);
            m2_ff[i]    <= rbsi_pkg::mag33(n2_ff[i]);
            neg1_ff[i]  <= n1_ff[i][32] ^ d_ff[i][32];
            neg2_ff[i]  <= n2_ff[i][32] ^ d_ff[i][32];
         end
      end
   end

   // dividers, with the parallel flags carried alongside
   logic signed [T_W-1:0] t1 [3], t2 [3];
   logic [2:0] par_dl_ff [NS+1], pmiss_dl_ff [NS+1];

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rbsi_div u_div1 (
         .clock   (clock),
         .en      (en),
         .num_mag (m1_ff[i]),
         .den     (den_ff[i]),
         .neg     (neg1_ff[i]),
         .t       (t1[i])
      );
      rbsi_div u_div2 (
         .clock   (clock),
         .en      (en),
         .num_mag (m2_ff[i]),
         .den     (den_ff[i]),
         .neg     (neg2_ff[i]),
         .t       (t2[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         par_dl_ff[0]   <= par_ff;
         pmiss_dl_ff[0] <= pmiss_ff;
         for (int k = 1; k <= NS; k++) begin
            par_dl_ff[k]   <= par_dl_ff[k-1];
            pmiss_dl_ff[k] <= pmiss_dl_ff[k-1];
         end
      end
   end

   // order stage: entry first, remember whether the pair was swapped
   logic signed [T_W-1:0] ten_ff [3], tex_ff [3];
   logic [2:0] swap_ff, par_o_ff, pmiss_o_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (t1[i] > t2[i]) begin
               ten_ff[i]  <= t2[i];
               tex_ff[i]  <= t1[i];
               swap_ff[i] <= 1'b1;
            end else begin
               ten_ff[i]  <= t1[i];
               tex_ff[i]  <= t2[i];
               swap_ff[i] <= 1'b0;
            end
         end
         par_o_ff   <= par_dl_ff[NS];
         pmiss_o_ff <= pmiss_dl_ff[NS];
      end
   end

   // fold stage: largest entry, smallest exit, axis by axis in order
   logic                     hit_in;
   logic [rbsi_pkg::ET_W-1:0] et_in;
   logic [1:0]               ax_in, sg_in;
   logic                     hit_ff;
   logic [rbsi_pkg::ET_W-1:0] et_ff;
   logic [1:0]               ax_ff, sg_ff;

   always_comb begin
      logic signed [T_W-1:0] tmin, tmax;
      logic [1:0] ax, sg;
      logic miss;
      tmin = '0;
      tmax = rbsi_pkg::ONE_T;
      ax   = rbsi_pkg::AXIS_X;
      sg   = rbsi_pkg::SIGN_NONE;
      miss = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (par_o_ff[i]) begin
            if (pmiss_o_ff[i]) miss = 1'b1;
         end else begin
            if (ten_ff[i] > tmin) begin
               tmin = ten_ff[i];
               ax   = 2'(i);
               sg   = swap_ff[i] ? rbsi_pkg::SIGN_POS : rbsi_pkg::SIGN_NEG;
            end
            if (tex_ff[i] < tmax) tmax = tex_ff[i];
            if (tmin > tmax) miss = 1'b1;
         end
      end
      hit_in = !miss && (tmin > 0);
      if (hit_in) begin
         et_in = tmin[rbsi_pkg::ET_W-1:0];
         ax_in = ax;
         sg_in = sg;
      end else begin
         et_in = rbsi_pkg::MISS_T;
         ax_in = rbsi_pkg::AXIS_X;
         sg_in = rbsi_pkg::SIGN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= hit_in;
         et_ff  <= et_in;
         ax_ff  <= ax_in;
         sg_ff  <= sg_in;
      end
   end

   assign rsp_chan.valid       = vld_ff[L-1];
   assign rsp_chan.hit         = hit_ff;
   assign rsp_chan.entry_t     = et_ff;
   assign rsp_chan.normal_axis = ax_ff;
   assign rsp_chan.normal_sign = sg_ff;

endmodule
